>>> sv/nlt_pkg.sv
`default_nettype none

package nlt_pkg;

    localparam int TAG_W  = 16;
    localparam int TIME_W = 40;
    localparam int CNT_W  = 32;
    localparam int SUM_W  = 48;
    localparam int KEEP_W = 5;
    localparam int RANK_W = 5;

    localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd10;

    // operation codes of an input word
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_REPLY   = 2'd1;
    localparam logic [1:0] OP_READOUT = 2'd2;

    // configuration register indexes
    localparam logic CFG_KEEP   = 1'b0;
    localparam logic CFG_ENABLE = 1'b1;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    typedef struct packed {
        logic [1:0]        operation;
        logic              selected;
        logic [TAG_W-1:0]  query_tag;
        logic [TIME_W-1:0] timestamp;
    } t_in_item;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              entry_valid;
        logic [TIME_W-1:0] duration;
        logic [TAG_W-1:0]  entry_tag;
        logic [CNT_W-1:0]  statement_count;
        logic [SUM_W-1:0]  total_time;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic [TIME_W-1:0] dur;
        logic [TAG_W-1:0]  tag;
    } t_entry;

    localparam int ENTRY_W = TIME_W + TAG_W;

endpackage

`default_nettype wire

>>> sv/nlt_ram.sv
`default_nettype none

module nlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> sv/top_n_latency_tracker.sv
`default_nettype none

// Keeps the longest-running requests in a list sorted longest first, held in
// one simple dual-port RAM with a registered read. A start event, a reply
// with nothing pending and an unused operation code are handled in the idle
// state. A reply that completes a request walks the list once, reading one
// entry per cycle and writing the shifted entries back behind the read. A
// readout gives one result word per cycle, back to back, each with o_strobe
// high for one cycle; the results cannot be held off, so the receiver must
// take every word as it comes. An empty list reads out as a single word with
// rank 0 and entry_valid 0. Configuration writes are taken at any time but
// belong in periods with busy low and no result pending.
module top_n_latency_tracker
    import nlt_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire t_in_item  i_item,
    output logic           o_strobe,
    output t_out_item      o_result,
    input  wire logic      i_cfg_we,
    input  wire logic      i_cfg_idx,
    input  wire logic [KEEP_W-1:0] i_cfg_data
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int HW = $clog2(MAX_ENTRIES + 1);
    localparam int CW = (HW > KEEP_W) ? HW : KEEP_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_INS  = 4'b0010,
        S_TAIL = 4'b0100,
        S_RD   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [KEEP_W-1:0] r_keep;
    logic              r_enable;
    logic              r_pending, n_pending;
    logic [TAG_W-1:0]  r_pend_tag, n_pend_tag;
    logic [TIME_W-1:0] r_start_time, n_start_time;
    logic [HW-1:0]     r_held, n_held;
    logic [CNT_W-1:0]  r_stmts, n_stmts;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [AW-1:0]     r_cnt, n_cnt;
    t_entry            r_carry, n_carry;
    logic              r_ins, n_ins;
    logic              r_grow, n_grow;
    logic              n_strobe;
    t_out_item         n_result;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry            rd_entry;

    logic              accept;
    logic [TIME_W-1:0] elapsed;
    logic [SUM_W:0]    sum_wide;
    logic [CW-1:0]     held_c;
    logic [CW-1:0]     keep_c;
    logic              at_end;

    assign accept   = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);
    assign rd_entry = t_entry'(ram_rdata);
    assign elapsed  = i_item.timestamp - r_start_time;
    assign sum_wide = {1'b0, r_sum} + {{(SUM_W + 1 - TIME_W){1'b0}}, elapsed};
    assign held_c   = CW'(r_held);
    assign keep_c   = CW'(r_keep);
    assign at_end   = (HW'(r_cnt) == r_held - HW'(1));

    nlt_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_ENTRIES)
    ) u_list (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ENTRY_W'(r_carry)),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_pending    = r_pending;
        n_pend_tag   = r_pend_tag;
        n_start_time = r_start_time;
        n_held       = r_held;
        n_stmts      = r_stmts;
        n_sum        = r_sum;
        n_cnt        = r_cnt;
        n_carry      = r_carry;
        n_ins        = r_ins;
        n_grow       = r_grow;
        n_strobe     = 1'b0;
        n_result     = o_result;
        ram_we       = 1'b0;
        ram_waddr    = r_cnt;
        ram_raddr    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_item.operation)
                        OP_START: begin
                            if (r_enable && i_item.selected) begin
                                if (r_stmts != CNT_MAX) begin
                                    n_stmts = r_stmts + CNT_W'(1);
                                end
                                n_pending    = 1'b1;
                                n_pend_tag   = i_item.query_tag;
                                n_start_time = i_item.timestamp;
                            end
                        end
                        OP_REPLY: begin
                            if (r_pending) begin
                                n_pending   = 1'b0;
                                n_sum       = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
                                n_carry.dur = elapsed;
                                n_carry.tag = r_pend_tag;
                                n_ins       = 1'b0;
                                n_cnt       = '0;
                                // list grows only while below the effective keep count
                                n_grow      = (held_c < keep_c) && (held_c < MAX_C);
                                n_state     = (r_held == '0) ? S_TAIL : S_INS;
                            end
                        end
                        OP_READOUT: begin
                            n_cnt = '0;
                            if (r_held == '0) begin
                                n_strobe                 = 1'b1;
                                n_result.rank            = '0;
                                n_result.entry_valid     = 1'b0;
                                n_result.duration        = '0;
                                n_result.entry_tag       = '0;
                                n_result.statement_count = r_stmts;
                                n_result.total_time      = r_sum;
                                n_result.last            = 1'b1;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_INS: begin
                // entry r_cnt is on the read port; ties stay ahead of the new word
                if (r_ins || (rd_entry.dur < r_carry.dur)) begin
                    ram_we  = 1'b1;
                    n_carry = rd_entry;
                    n_ins   = 1'b1;
                end
                if (at_end) begin
                    n_state = S_TAIL;
                end else begin
                    n_cnt     = r_cnt + AW'(1);
                    ram_raddr = r_cnt + AW'(1);
                end
            end

            S_TAIL: begin
                ram_waddr = r_held[AW-1:0];
                if (r_grow) begin
                    ram_we = 1'b1;
                    n_held = r_held + HW'(1);
                end
                n_state = S_IDLE;
            end

            S_RD: begin
                n_strobe                 = 1'b1;
                n_result.rank            = RANK_W'(CW'(r_cnt) + CW'(1));
                n_result.entry_valid     = 1'b1;
                n_result.duration        = rd_entry.dur;
                n_result.entry_tag       = rd_entry.tag;
                n_result.statement_count = r_stmts;
                n_result.total_time      = r_sum;
                n_result.last            = at_end;
                if (at_end) begin
                    n_state = S_IDLE;
                end else begin
                    n_cnt     = r_cnt + AW'(1);
                    ram_raddr = r_cnt + AW'(1);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_keep       <= KEEP_RESET;
            r_enable     <= 1'b1;
            r_pending    <= 1'b0;
            r_pend_tag   <= '0;
            r_start_time <= '0;
            r_held       <= '0;
            r_stmts      <= '0;
            r_sum        <= '0;
            o_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pending    <= n_pending;
            r_pend_tag   <= n_pend_tag;
            r_start_time <= n_start_time;
            r_held       <= n_held;
            r_stmts      <= n_stmts;
            r_sum        <= n_sum;
            o_strobe     <= n_strobe;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_KEEP:   r_keep   <= i_cfg_data;
                    CFG_ENABLE: r_enable <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_carry  <= n_carry;
        r_ins    <= n_ins;
        r_grow   <= n_grow;
        o_result <= n_result;
    end

endmodule

`default_nettype wire
